@@ rtl/core/e2c_pkg.sv @@
package e2c_pkg;

    localparam int NUM_STG = 10;
    localparam int SECS_W  = 32;
    localparam int RES_W   = 48;

    // seconds per day is 675 << 7, divided as (secs >> 7) / 675
    localparam logic [9:0]  DAY_DIV    = 10'd675;
    localparam logic [25:0] DAY_RECIP  = 26'd50903316;
    localparam logic [17:0] HOUR_RECIP = 18'd149130;
    localparam logic [11:0] SEC_HOUR   = 12'd3600;
    localparam logic [12:0] MIN_RECIP  = 13'd4369;
    localparam logic [5:0]  SEC_MIN    = 6'd60;
    localparam logic [15:0] CYC_RECIP  = 16'd45933;
    localparam logic [10:0] DAYS_CYC   = 11'd1461;

    // day count from 1968-01-01, with a phantom feb 29 inserted in 2100
    localparam logic [15:0] EPOCH_OFFSET = 16'd731;
    localparam logic [15:0] SKIP_DAY     = 16'd47541;
    localparam logic [15:0] WDAY_OFFSET  = 16'd4;
    localparam logic [7:0]  YEAR_BASE    = 8'd68;
    localparam logic [7:0]  YEAR_2100    = 8'd200;
    localparam logic [8:0]  LEAP_DAY     = 9'd59;
    localparam logic [10:0] YEAR1_START  = 11'd366;
    localparam logic [10:0] YEAR2_START  = 11'd731;
    localparam logic [10:0] YEAR3_START  = 11'd1096;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
    } cal_t;

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] base;
        case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return (leap && (mon >= 4'd2)) ? base + 9'd1 : base;
    endfunction

endpackage

@@ rtl/core/e2c_path.sv @@
module e2c_path
    import e2c_pkg::*;
(
    input  logic              aclk,
    input  logic [NUM_STG-1:0] en,
    input  logic [SECS_W-1:0] secs,
    output cal_t              res
);

    logic [24:0] st1_s7_reg, st1_s7_next;
    logic [6:0]  st1_lo_reg, st1_lo_next;
    logic [15:0] st1_q_reg, st1_q_next;
    logic [50:0] prod_day;

    logic [15:0] st2_q_reg, st2_q_next;
    logic [10:0] st2_r_reg, st2_r_next;
    logic [6:0]  st2_lo_reg, st2_lo_next;
    logic [24:0] diff_day;

    logic [15:0] st3_days_reg, st3_days_next;
    logic [16:0] st3_clock_reg, st3_clock_next;
    logic [10:0] rfix_day;

    logic [16:0] st4_clock_reg, st4_clock_next;
    logic [4:0]  st4_hest_reg, st4_hest_next;
    logic [15:0] st4_d2_reg, st4_d2_next;
    logic [2:0]  st4_wday_reg, st4_wday_next;
    logic [34:0] prod_hour;
    logic [15:0] wd_x;
    logic [5:0]  wd_s1;
    logic [3:0]  wd_s2;

    logic [4:0]  st5_hest_reg, st5_hest_next;
    logic [12:0] st5_hr_r_reg, st5_hr_r_next;
    logic [15:0] st5_d2_reg, st5_d2_next;
    logic [5:0]  st5_cest_reg, st5_cest_next;
    logic [2:0]  st5_wday_reg, st5_wday_next;
    logic [16:0] diff_hour;
    logic [31:0] prod_cyc;

    logic [4:0]  st6_hour_reg, st6_hour_next;
    logic [11:0] st6_rem_reg, st6_rem_next;
    logic [5:0]  st6_cest_reg, st6_cest_next;
    logic [11:0] st6_cyc_r_reg, st6_cyc_r_next;
    logic [2:0]  st6_wday_reg, st6_wday_next;
    logic [12:0] rfix_hour;
    logic [15:0] diff_cyc;

    logic [4:0]  st7_hour_reg, st7_hour_next;
    logic [11:0] st7_rem_reg, st7_rem_next;
    logic [5:0]  st7_mest_reg, st7_mest_next;
    logic [5:0]  st7_cyc_reg, st7_cyc_next;
    logic [10:0] st7_cr_reg, st7_cr_next;
    logic [2:0]  st7_wday_reg, st7_wday_next;
    logic [24:0] prod_min;
    logic [11:0] rfix_cyc;

    logic [4:0]  st8_hour_reg, st8_hour_next;
    logic [2:0]  st8_wday_reg, st8_wday_next;
    logic [6:0]  st8_min_r_reg, st8_min_r_next;
    logic [5:0]  st8_mest_reg, st8_mest_next;
    logic [7:0]  st8_years_reg, st8_years_next;
    logic        st8_leap_reg, st8_leap_next;
    logic [8:0]  st8_yday_reg, st8_yday_next;
    logic [11:0] diff_min;
    logic [1:0]  yi;
    logic [10:0] yrem;

    logic [4:0]  st9_hour_reg, st9_hour_next;
    logic [2:0]  st9_wday_reg, st9_wday_next;
    logic [7:0]  st9_years_reg, st9_years_next;
    logic [5:0]  st9_minute_reg, st9_minute_next;
    logic [5:0]  st9_second_reg, st9_second_next;
    logic        st9_leap_reg, st9_leap_next;
    logic [8:0]  st9_yfake_reg, st9_yfake_next;
    logic [8:0]  st9_yday_reg, st9_yday_next;
    logic [3:0]  st9_month_reg, st9_month_next;
    logic [6:0]  rfix_min;

    cal_t        st10_reg, st10_next;
    logic [8:0]  dom_full;

    // days and seconds of day
    always_comb begin
        st1_s7_next = secs[31:7];
        st1_lo_next = secs[6:0];
        prod_day    = 51'(secs[31:7]) * 51'(DAY_RECIP);
        st1_q_next  = prod_day[50:35];
    end

    always_comb begin
        diff_day    = st1_s7_reg - 25'(st1_q_reg) * 25'(DAY_DIV);
        st2_q_next  = st1_q_reg;
        st2_r_next  = diff_day[10:0];
        st2_lo_next = st1_lo_reg;
    end

    always_comb begin
        if (st2_r_reg >= 11'(DAY_DIV)) begin
            st3_days_next = st2_q_reg + 16'd1;
            rfix_day      = st2_r_reg - 11'(DAY_DIV);
        end else begin
            st3_days_next = st2_q_reg;
            rfix_day      = st2_r_reg;
        end
        st3_clock_next = {rfix_day[9:0], st2_lo_reg};
    end

    // hour estimate, weekday, shifted day count
    always_comb begin
        prod_hour      = 35'(st3_clock_reg) * 35'(HOUR_RECIP);
        st4_hest_next  = prod_hour[33:29];
        st4_clock_next = st3_clock_reg;
        st4_d2_next    = st3_days_reg + EPOCH_OFFSET
                         + ((st3_days_reg >= SKIP_DAY) ? 16'd1 : 16'd0);
        wd_x  = st3_days_reg + WDAY_OFFSET;
        wd_s1 = 6'(wd_x[2:0]) + 6'(wd_x[5:3]) + 6'(wd_x[8:6])
                + 6'(wd_x[11:9]) + 6'(wd_x[14:12]) + 6'(wd_x[15]);
        wd_s2 = 4'(wd_s1[5:3]) + 4'(wd_s1[2:0]);
        st4_wday_next = (wd_s2 >= 4'd7) ? 3'(wd_s2 - 4'd7) : wd_s2[2:0];
    end

    always_comb begin
        diff_hour     = st4_clock_reg - 17'(st4_hest_reg) * 17'(SEC_HOUR);
        st5_hr_r_next = diff_hour[12:0];
        st5_hest_next = st4_hest_reg;
        prod_cyc      = 32'(st4_d2_reg) * 32'(CYC_RECIP);
        st5_cest_next = prod_cyc[31:26];
        st5_d2_next   = st4_d2_reg;
        st5_wday_next = st4_wday_reg;
    end

    always_comb begin
        if (st5_hr_r_reg >= 13'(SEC_HOUR)) begin
            st6_hour_next = st5_hest_reg + 5'd1;
            rfix_hour     = st5_hr_r_reg - 13'(SEC_HOUR);
        end else begin
            st6_hour_next = st5_hest_reg;
            rfix_hour     = st5_hr_r_reg;
        end
        st6_rem_next   = rfix_hour[11:0];
        diff_cyc       = st5_d2_reg - 16'(st5_cest_reg) * 16'(DAYS_CYC);
        st6_cyc_r_next = diff_cyc[11:0];
        st6_cest_next  = st5_cest_reg;
        st6_wday_next  = st5_wday_reg;
    end

    always_comb begin
        prod_min      = 25'(st6_rem_reg) * 25'(MIN_RECIP);
        st7_mest_next = prod_min[23:18];
        st7_rem_next  = st6_rem_reg;
        st7_hour_next = st6_hour_reg;
        st7_wday_next = st6_wday_reg;
        if (st6_cyc_r_reg >= 12'(DAYS_CYC)) begin
            st7_cyc_next = st6_cest_reg + 6'd1;
            rfix_cyc     = st6_cyc_r_reg - 12'(DAYS_CYC);
        end else begin
            st7_cyc_next = st6_cest_reg;
            rfix_cyc     = st6_cyc_r_reg;
        end
        st7_cr_next = rfix_cyc[10:0];
    end

    // minute remainder and year within the four year cycle
    always_comb begin
        diff_min       = st7_rem_reg - 12'(st7_mest_reg) * 12'(SEC_MIN);
        st8_min_r_next = diff_min[6:0];
        st8_mest_next  = st7_mest_reg;
        st8_hour_next  = st7_hour_reg;
        st8_wday_next  = st7_wday_reg;
        if (st7_cr_reg < YEAR1_START) begin
            yi   = 2'd0;
            yrem = st7_cr_reg;
        end else if (st7_cr_reg < YEAR2_START) begin
            yi   = 2'd1;
            yrem = st7_cr_reg - YEAR1_START;
        end else if (st7_cr_reg < YEAR3_START) begin
            yi   = 2'd2;
            yrem = st7_cr_reg - YEAR2_START;
        end else begin
            yi   = 2'd3;
            yrem = st7_cr_reg - YEAR3_START;
        end
        st8_leap_next  = (yi == 2'd0);
        st8_yday_next  = yrem[8:0];
        st8_years_next = YEAR_BASE + {st7_cyc_reg, 2'b00} + 8'(yi);
    end

    always_comb begin
        if (st8_min_r_reg >= 7'(SEC_MIN)) begin
            st9_minute_next = st8_mest_reg + 6'd1;
            rfix_min        = st8_min_r_reg - 7'(SEC_MIN);
        end else begin
            st9_minute_next = st8_mest_reg;
            rfix_min        = st8_min_r_reg;
        end
        st9_second_next = rfix_min[5:0];
        st9_hour_next   = st8_hour_reg;
        st9_wday_next   = st8_wday_reg;
        st9_years_next  = st8_years_reg;
        st9_leap_next   = st8_leap_reg;
        st9_yfake_next  = st8_yday_reg;
        // 2100 carries a phantom feb 29
        if ((st8_years_reg == YEAR_2100) && (st8_yday_reg > LEAP_DAY)) begin
            st9_yday_next = st8_yday_reg - 9'd1;
        end else begin
            st9_yday_next = st8_yday_reg;
        end
        st9_month_next = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (st8_yday_reg >= month_start(st8_leap_reg, 4'(m))) begin
                st9_month_next = st9_month_next + 4'd1;
            end
        end
    end

    always_comb begin
        dom_full = st9_yfake_reg - month_start(st9_leap_reg, st9_month_reg) + 9'd1;
        st10_next.second           = st9_second_reg;
        st10_next.minute           = st9_minute_reg;
        st10_next.hour             = st9_hour_reg;
        st10_next.weekday          = st9_wday_reg;
        st10_next.years_since_1900 = st9_years_reg;
        st10_next.day_of_year      = st9_yday_reg;
        st10_next.month            = st9_month_reg;
        st10_next.day_of_month     = dom_full[4:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st1_s7_reg <= st1_s7_next;
            st1_lo_reg <= st1_lo_next;
            st1_q_reg  <= st1_q_next;
        end
        if (en[1]) begin
            st2_q_reg  <= st2_q_next;
            st2_r_reg  <= st2_r_next;
            st2_lo_reg <= st2_lo_next;
        end
        if (en[2]) begin
            st3_days_reg  <= st3_days_next;
            st3_clock_reg <= st3_clock_next;
        end
        if (en[3]) begin
            st4_clock_reg <= st4_clock_next;
            st4_hest_reg  <= st4_hest_next;
            st4_d2_reg    <= st4_d2_next;
            st4_wday_reg  <= st4_wday_next;
        end
        if (en[4]) begin
            st5_hest_reg <= st5_hest_next;
            st5_hr_r_reg <= st5_hr_r_next;
            st5_d2_reg   <= st5_d2_next;
            st5_cest_reg <= st5_cest_next;
            st5_wday_reg <= st5_wday_next;
        end
        if (en[5]) begin
            st6_hour_reg  <= st6_hour_next;
            st6_rem_reg   <= st6_rem_next;
            st6_cest_reg  <= st6_cest_next;
            st6_cyc_r_reg <= st6_cyc_r_next;
            st6_wday_reg  <= st6_wday_next;
        end
        if (en[6]) begin
            st7_hour_reg <= st7_hour_next;
            st7_rem_reg  <= st7_rem_next;
            st7_mest_reg <= st7_mest_next;
            st7_cyc_reg  <= st7_cyc_next;
            st7_cr_reg   <= st7_cr_next;
            st7_wday_reg <= st7_wday_next;
        end
        if (en[7]) begin
            st8_hour_reg  <= st8_hour_next;
            st8_wday_reg  <= st8_wday_next;
            st8_min_r_reg <= st8_min_r_next;
            st8_mest_reg  <= st8_mest_next;
            st8_years_reg <= st8_years_next;
            st8_leap_reg  <= st8_leap_next;
            st8_yday_reg  <= st8_yday_next;
        end
        if (en[8]) begin
            st9_hour_reg   <= st9_hour_next;
            st9_wday_reg   <= st9_wday_next;
            st9_years_reg  <= st9_years_next;
            st9_minute_reg <= st9_minute_next;
            st9_second_reg <= st9_second_next;
            st9_leap_reg   <= st9_leap_next;
            st9_yfake_reg  <= st9_yfake_next;
            st9_yday_reg   <= st9_yday_next;
            st9_month_reg  <= st9_month_next;
        end
        if (en[9]) begin
            st10_reg <= st10_next;
        end
    end

    assign res = st10_reg;

endmodule

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// unsigned 32-bit seconds since 1970-01-01 00:00 utc to broken-down utc time
// input stream s_*: s_tdata carries the seconds count, one word per timestamp
// result stream m_*: one calendar word for every input word, in order
// ten register stages: a word accepted into the first stage moves through
// every later stage in order before it shows on m_tdata; the stage count is set
// by the chained constant-reciprocal divides, each a multiply, a subtract and
// a one-step remainder correction in the stage after it
// throughput is one word per cycle while m_tready stays high, since every
// stage takes a new word each cycle
// every stage has its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up while m_tready is low and
// s_tready drops only once all ten stages hold words
// a stalled result holds on m_tdata until taken, nothing is lost or repeated
// aresetn low clears all valid bits; words in flight are dropped
// gregorian leap rules apply; the largest input gives 2106-02-07 06:28:15
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SECS_W-1:0] s_tdata,  // seconds_since_epoch[31:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RES_W-1:0]  m_tdata   // second[5:0], minute[11:6], hour[16:12],
                                        // weekday[19:17], years_since_1900[27:20],
                                        // day_of_year[36:28], month[40:37],
                                        // day_of_month[45:41], zero[47:46]
);

    logic [NUM_STG-1:0] vld_reg, vld_next;
    logic [NUM_STG-1:0] en;
    cal_t               res;

    always_comb begin
        en[NUM_STG-1] = !vld_reg[NUM_STG-1] || m_tready;
        for (int i = NUM_STG - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NUM_STG; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    e2c_path u_path (
        .aclk (aclk),
        .en   (en),
        .secs (s_tdata),
        .res  (res)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NUM_STG-1];
    assign m_tdata  = {2'b00, res.day_of_month, res.month, res.day_of_year,
                       res.years_since_1900, res.weekday, res.hour, res.minute,
                       res.second};

endmodule

@@ tb/tb_epoch_seconds_to_calendar.sv @@
module tb_epoch_seconds_to_calendar;
    timeunit 1ns;
    timeprecision 1ps;

    import e2c_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [SECS_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;

    cal_t        pending_dates[$];
    cal_t        want_date;
    int unsigned mismatch_count = 0;
    int unsigned src_gap_max = 18;
    int unsigned sink_gap_max = 18;
    int unsigned sink_hold = 0;

    epoch_seconds_to_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input bit leap, input int unsigned m);
        case (m)
            1: begin
                return leap ? 29 : 28;
            end
            3, 5, 8, 10: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic cal_t to_calendar(input logic [31:0] secs);
        cal_t        r;
        int unsigned tod;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        bit          leap;
        tod  = secs % 86400;
        days = secs / 86400;
        r.second  = 6'(tod % 60);
        r.minute  = 6'((tod % 3600) / 60);
        r.hour    = 5'(tod / 3600);
        r.weekday = 3'((days + 4) % 7);
        yr = 1970;
        while (days >= (is_leap_year(yr) ? 366 : 365)) begin
            days -= is_leap_year(yr) ? 366 : 365;
            yr++;
        end
        r.years_since_1900 = 8'(yr - 1900);
        r.day_of_year      = 9'(days);
        leap = is_leap_year(yr);
        mon  = 0;
        while (mon < 11 && days >= days_in_month(leap, mon)) begin
            days -= days_in_month(leap, mon);
            mon++;
        end
        r.month        = 4'(mon);
        r.day_of_month = 5'(days + 1);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker and input monitor share one edge so ordering is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_dates.size() == 0) begin
                    $error("result word %h with nothing pending", m_tdata);
                    mismatch_count++;
                end else begin
                    want_date = pending_dates.pop_front();
                    check_field("second", want_date.second, m_tdata[5:0]);
                    check_field("minute", want_date.minute, m_tdata[11:6]);
                    check_field("hour", want_date.hour, m_tdata[16:12]);
                    check_field("weekday", want_date.weekday, m_tdata[19:17]);
                    check_field("years_since_1900", want_date.years_since_1900,
                                m_tdata[27:20]);
                    check_field("day_of_year", want_date.day_of_year, m_tdata[36:28]);
                    check_field("month", want_date.month, m_tdata[40:37]);
                    check_field("day_of_month", want_date.day_of_month, m_tdata[45:41]);
                    check_field("pad", 0, m_tdata[47:46]);
                end
            end
            if (s_tvalid && s_tready) begin
                pending_dates.push_back(to_calendar(s_tdata));
            end
        end
    end

    // result sink: random stall after each word, plus an optional long hold
    initial begin : result_sink
        int unsigned wait_left;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                wait_left = $urandom_range(0, sink_gap_max);
            end
            @(negedge aclk);
            if (sink_hold > 0) begin
                wait_left = sink_hold;
                sink_hold = 0;
            end
            if (wait_left > 0) begin
                m_tready <= 1'b0;
                wait_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer_seconds(input logic [31:0] secs);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic test_field_extremes();
        offer_seconds(32'd0);
        offer_seconds(32'd1);
        offer_seconds(32'd59);
        offer_seconds(32'd60);
        offer_seconds(32'd3599);
        offer_seconds(32'd3600);
        offer_seconds(32'd86399);
        offer_seconds(32'd86400);
        offer_seconds(32'd68169600);     // 1972-02-29, first leap day
        offer_seconds(32'd94694399);     // end of 1972
        offer_seconds(32'd94694400);
        offer_seconds(32'd951782400);    // 2000-02-29, leap by the 400 rule
        offer_seconds(32'd951868800);
        offer_seconds(32'd978307199);    // day 365 of 2000
        offer_seconds(32'h7FFF_FFFF);
        offer_seconds(32'h8000_0000);
        offer_seconds(32'd4102444799);   // end of 2099
        offer_seconds(32'd4107542399);   // 2100-02-28, no leap by the 100 rule
        offer_seconds(32'd4107542400);   // 2100-03-01
        offer_seconds(32'hAAAA_AAAA);
        offer_seconds(32'h5555_5555);
        offer_seconds(32'hFFFF_FFFE);
        offer_seconds(32'hFFFF_FFFF);    // last representable second
    endtask

    task automatic test_uniform_spread(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            src_gap_max  = ((k / 50) % 2 == 1) ? 0 : 18;
            sink_gap_max = ((k / 40) % 3 == 0) ? 0 : 18;
            offer_seconds($urandom);
        end
        src_gap_max  = 18;
        sink_gap_max = 18;
    endtask

    // seconds around the start of a random month of a random year
    task automatic test_calendar_boundaries(input int unsigned count);
        int unsigned k;
        int unsigned y;
        int unsigned yr;
        int unsigned mon;
        int unsigned day_count;
        logic [31:0] secs;
        for (k = 0; k < count; k++) begin
            yr  = $urandom_range(1970, 2105);
            mon = $urandom_range(0, 11);
            day_count = 0;
            for (y = 1970; y < yr; y++) begin
                day_count += is_leap_year(y) ? 366 : 365;
            end
            for (y = 0; y < mon; y++) begin
                day_count += days_in_month(is_leap_year(yr), y);
            end
            secs = 32'(day_count * 86400);
            case ($urandom_range(0, 2))
                0: begin
                    secs = secs - 32'd1;
                end
                1: begin
                end
                default: begin
                    secs = secs + 32'($urandom_range(0, 2 * 86400 - 1)) - 32'd86400;
                end
            endcase
            offer_seconds(secs);
        end
    endtask

    task automatic test_back_to_back(input int unsigned count);
        int unsigned k;
        src_gap_max  = 0;
        sink_gap_max = 0;
        for (k = 0; k < count; k++) begin
            offer_seconds($urandom);
        end
        src_gap_max  = 18;
        sink_gap_max = 18;
    endtask

    // sink holds off long enough for the pipeline to fill and stall the input
    task automatic test_output_stall(input int unsigned count);
        int unsigned k;
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold    = 60;
        for (k = 0; k < count; k++) begin
            offer_seconds($urandom);
        end
        src_gap_max  = 18;
        sink_gap_max = 18;
        for (k = 0; k < count / 2; k++) begin
            offer_seconds($urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_uniform_spread(250);
        test_calendar_boundaries(200);
        test_back_to_back(100);
        test_output_stall(40);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
